// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the correlation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/ocm_pkg.sv -----
package ocm_pkg;

    localparam int VAL_W  = 24;
    localparam int DIFF_W = 25;
    localparam int PROD_W = 50;
    localparam int SUM_W  = 64;
    localparam int CORR_W = 16;
    localparam int IDX_W  = 2;
    localparam int CFG_IDX_W = 2;

    // a run length that cannot saturate a sum
    localparam int MAX_SAMPLES = 4096;

    localparam logic signed [VAL_W-1:0] BASE_RESET_0 = 24'sd29360;
    localparam logic signed [VAL_W-1:0] BASE_RESET_1 = 24'sd39846;
    localparam logic signed [VAL_W-1:0] BASE_RESET_2 = 24'sd33554;
    localparam logic signed [VAL_W-1:0] BASE_RESET_3 = 24'sd34603;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ACC   = 7'b0000010,
        ST_LOAD  = 7'b0000100,
        ST_NORM  = 7'b0001000,
        ST_SQRT  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;    // latch sample differences
        logic acc_clear;  // restart entry counter
        logic acc_step;   // accumulate one entry
        logic load;       // fetch operands for current coefficient
        logic norm_step;  // one normalize step
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic emit;       // drive one result word
        logic clear;      // clear sums and overflow flag
    } t_cmd;

    typedef struct packed {
        logic acc_last;   // current entry is the last one
        logic norm_done;
        logic sqrt_done;
        logic div_done;
        logic emit_last;  // last coefficient of the matrix
    } t_status;

endpackage

// ----- hw/rtl/offset_correlation_matrix_core.sv -----
// Correlation matrix core. Raise start with a sample word; it is taken at the first rising
// edge with busy low. Each sample keeps busy high while it is accumulated, one
// multiply-accumulate per matrix entry through a single shared 25x25 multiplier, so a
// new sample is taken only once busy has fallen. After a sample with i_final_sample set,
// the core emits 16 result words, one per coefficient in row-major order. Each
// coefficient runs a load step, normalize steps whose number depends on the size of
// the two variances, a 31-step square root and its finish step, a 49-step divider and an output step.
// Each word is on the outputs for exactly one cycle with o_valid high and cannot be
// stalled, so the receiver must take every word as it comes. busy stays high until the
// cycle after the last word, when the sums have been cleared.
`include "assert_macros.svh"

module offset_correlation_matrix_core
    import ocm_pkg::*;
#(
    parameter int NUM_VARS    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [VAL_W-1:0]     i_sample_value_0,
    input  logic signed [VAL_W-1:0]     i_sample_value_1,
    input  logic signed [VAL_W-1:0]     i_sample_value_2,
    input  logic signed [VAL_W-1:0]     i_sample_value_3,
    input  logic                        i_final_sample,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [VAL_W-1:0]            i_cfg_data,
    output logic                        o_valid,
    output logic [IDX_W-1:0]            o_row_index,
    output logic [IDX_W-1:0]            o_column_index,
    output logic signed [CORR_W-1:0]    o_correlation,
    output logic                        o_undefined_flag,
    output logic                        o_saturated_flag,
    output logic                        o_last_of_matrix
);

    logic signed [VAL_W-1:0] r_base [4];
    logic signed [VAL_W-1:0] vals   [4];
    t_cmd    cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base[0] <= BASE_RESET_0;
            r_base[1] <= BASE_RESET_1;
            r_base[2] <= BASE_RESET_2;
            r_base[3] <= BASE_RESET_3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_base[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // unused positions read as zero difference
    always_comb begin
        vals[0] = i_sample_value_0;
        vals[1] = i_sample_value_1;
        vals[2] = i_sample_value_2;
        vals[3] = i_sample_value_3;
    end

    logic signed [VAL_W-1:0] vals_m [4];
    logic signed [VAL_W-1:0] base_m [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            vals_m[k] = (k < NUM_VARS) ? vals[k]   : '0;
            base_m[k] = (k < NUM_VARS) ? r_base[k] : '0;
        end
    end

    ocm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start && !busy),
        .i_final  (i_final_sample),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    ocm_datapath #(.NUM_VARS(NUM_VARS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_val    (vals_m),
        .i_base   (base_m),
        .o_status (status),
        .o_valid  (o_valid),
        .o_row    (o_row_index),
        .o_col    (o_column_index),
        .o_corr   (o_correlation),
        .o_undef  (o_undefined_flag),
        .o_sat    (o_saturated_flag),
        .o_last   (o_last_of_matrix)
    );

    logic last_word, last_ok;
    assign last_word = o_valid && o_last_of_matrix;
    assign last_ok   = !last_word || (o_row_index == o_column_index);

    `ASSERT_CLK(a_valid_busy, i_clk, i_rst_n, !o_valid || busy, "result word while idle")
    `ASSERT_CLK(a_last_valid, i_clk, i_rst_n, last_ok, "last word off diagonal")
    `ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, last_word, !busy, "busy after last word")

endmodule

// ----- hw/rtl/ocm_ctrl.sv -----
module ocm_ctrl
    import ocm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_final,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state, n_state;
    logic   r_final, n_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

    always_comb begin
        n_state = r_state;
        n_final = r_final;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture   = 1'b1;
                    o_cmd.acc_clear = 1'b1;
                    n_final         = i_final;
                    n_state         = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.acc_step = 1'b1;
                if (i_status.acc_last) begin
                    o_cmd.acc_clear = 1'b1;
                    n_state = r_final ? ST_LOAD : ST_IDLE;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_NORM;
            end
            ST_NORM: begin
                o_cmd.norm_step = 1'b1;
                if (i_status.norm_done) begin
                    o_cmd.sqrt_init = 1'b1;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.sqrt_done) begin
                    n_state = ST_DIV;
                    o_cmd.div_init = 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.emit_last) begin
                    o_cmd.clear = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ----- hw/rtl/ocm_datapath.sv -----
module ocm_datapath
    import ocm_pkg::*;
#(
    parameter int NUM_VARS = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic signed [VAL_W-1:0]  i_val [4],
    input  logic signed [VAL_W-1:0]  i_base [4],
    output t_status                  o_status,
    output logic                     o_valid,
    output logic [IDX_W-1:0]         o_row,
    output logic [IDX_W-1:0]         o_col,
    output logic signed [CORR_W-1:0] o_corr,
    output logic                     o_undef,
    output logic                     o_sat,
    output logic                     o_last
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VARS - 1);
    localparam logic signed [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};

    logic signed [DIFF_W-1:0] r_diff [4];
    logic signed [SUM_W-1:0]  r_sum [4][4];
    logic                     r_ovf;
    logic [IDX_W-1:0]         r_i, r_j;

    // accumulate: one entry per cycle
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  acc_in, add_res;
    logic                     pos_ovf, neg_ovf;

    assign prod    = PROD_W'(r_diff[r_i]) * PROD_W'(r_diff[r_j]);
    assign acc_in  = r_sum[r_i][r_j];
    assign add_res = acc_in + SUM_W'(prod);
    assign pos_ovf = !prod[PROD_W-1] && !acc_in[SUM_W-1] && add_res[SUM_W-1];
    assign neg_ovf = prod[PROD_W-1] && acc_in[SUM_W-1] && !add_res[SUM_W-1];

    logic last_pos;
    assign last_pos = (r_i == LAST_IDX) && (r_j == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0;
            r_i   <= '0;
            r_j   <= '0;
            for (int a = 0; a < 4; a++)
                for (int b = 0; b < 4; b++)
                    r_sum[a][b] <= '0;
        end else begin
            if (i_cmd.capture) begin
                for (int k = 0; k < 4; k++)
                    r_diff[k] <= DIFF_W'(i_val[k]) - DIFF_W'(i_base[k]);
            end
            if (i_cmd.acc_step) begin
                if (pos_ovf) begin
                    r_sum[r_i][r_j] <= SMAX;
                    r_ovf <= 1'b1;
                end else if (neg_ovf) begin
                    r_sum[r_i][r_j] <= SMIN;
                    r_ovf <= 1'b1;
                end else begin
                    r_sum[r_i][r_j] <= add_res;
                end
            end
            if (i_cmd.clear) begin
                r_ovf <= 1'b0;
                for (int a = 0; a < 4; a++)
                    for (int b = 0; b < 4; b++)
                        r_sum[a][b] <= '0;
            end
            if (i_cmd.acc_clear || i_cmd.clear) begin
                r_i <= '0;
                r_j <= '0;
            end else if (i_cmd.acc_step || i_cmd.emit) begin
                if (r_j == LAST_IDX) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end
    end

    // coefficient unit
    logic [SUM_W-1:0] r_a, r_b, r_n;
    logic             r_neg, r_undef;
    logic [5:0]       r_kab;
    logic [61:0]      r_x;
    logic [61:0]      r_res, r_bit;
    logic [31:0]      r_d;
    logic [5:0]       r_cnt;

    logic a_big, b_big;
    assign a_big = |r_a[SUM_W-1:31];
    assign b_big = |r_b[SUM_W-1:31];

    logic [61:0] sq_sum;
    assign sq_sum = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a     <= r_sum[r_i][r_i];
            r_b     <= r_sum[r_j][r_j];
            r_undef <= (r_sum[r_i][r_i] == '0) || (r_sum[r_j][r_j] == '0);
            r_neg   <= r_sum[r_i][r_j][SUM_W-1];
            r_n     <= r_sum[r_i][r_j][SUM_W-1] ? (SUM_W'(0) - r_sum[r_i][r_j])
                                                : r_sum[r_i][r_j];
            r_kab   <= '0;
        end
        if (i_cmd.norm_step) begin
            if (a_big) begin
                r_a   <= r_a >> 2;
                r_kab <= r_kab + 1'b1;
            end else if (b_big) begin
                r_b   <= r_b >> 2;
                r_kab <= r_kab + 1'b1;
            end else begin
                r_n <= r_n >> r_kab;
            end
        end
        if (i_cmd.sqrt_init) begin
            r_x   <= 62'(r_a[30:0] * r_b[30:0]);
            r_res <= '0;
            r_bit <= 62'd1 << 60;
        end
        if (i_cmd.sqrt_step && (r_bit != '0)) begin
            if (r_x >= sq_sum) begin
                r_x   <= r_x - sq_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_init) begin
            r_d   <= 32'(r_res);
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Direct quotient: q = (n*2^16 + d) / (2d). d < 2^31 here; the case n >= d is handled by q_sel.
    logic [48:0] r_num;
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init)
            r_num <= {r_n[31:0], 16'd0} + 49'(r_res);
        else if (i_cmd.div_step)
            r_num <= {r_num[47:0], 1'b0};
    end

    logic [49:0] r_dr;
    logic [16:0] r_qq;
    logic [49:0] dr_try;
    assign dr_try = {r_dr[48:0], r_num[48]};
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_dr <= '0;
            r_qq <= '0;
        end else if (i_cmd.div_step) begin
            if (dr_try >= {17'd0, r_d, 1'b0}) begin
                r_dr <= dr_try - {17'd0, r_d, 1'b0};
                r_qq <= {r_qq[15:0], 1'b1};
            end else begin
                r_dr <= dr_try;
                r_qq <= {r_qq[15:0], 1'b0};
            end
        end
    end

    logic [16:0] q_sel;
    always_comb begin
        if (r_undef)
            q_sel = '0;
        else if (r_n >= SUM_W'(r_d))
            q_sel = 17'd32768;
        else
            q_sel = r_qq;
    end

    logic signed [CORR_W-1:0] corr_val;
    always_comb begin
        if (r_neg)
            corr_val = CORR_W'(17'd0 - q_sel);
        else if (q_sel > 17'd32767)
            corr_val = 16'sd32767;
        else
            corr_val = CORR_W'(q_sel);
    end

    assign o_status.acc_last  = last_pos;
    assign o_status.norm_done = !a_big && !b_big;
    assign o_status.sqrt_done = (r_bit == '0);
    assign o_status.div_done  = (r_cnt == 6'd48);
    assign o_status.emit_last = last_pos;

    assign o_valid = i_cmd.emit;
    assign o_row   = r_i;
    assign o_col   = r_j;
    assign o_corr  = corr_val;
    assign o_undef = r_undef;
    assign o_sat   = r_ovf;
    assign o_last  = last_pos;

endmodule
